### hdl/jgc_pkg.sv
// Shared types and constants for the joystick gesture classifier.
package jgc_pkg;

  localparam int unsigned QONE = 2048;
  localparam logic [31:0] SWIPE_MS = 32'd250;
  localparam logic [31:0] BACK_GAP_MS = 32'd350;
  localparam int unsigned ATAN_LEN = 24;

  // Configuration register indexes
  localparam logic [2:0] REG_DEAD_ZONE = 3'd0;
  localparam logic [2:0] REG_CIRCLE_MAX_MS = 3'd1;
  localparam logic [2:0] REG_CIRCLE_MIN_ARC = 3'd2;
  localparam logic [2:0] REG_FLICK_MIN_STEP = 3'd3;
  localparam logic [2:0] REG_FLICK_MAX_MS = 3'd4;
  localparam logic [2:0] REG_SIDEWAYS_THRESHOLD = 3'd5;
  localparam logic [2:0] REG_SIDEWAYS_HOLD_MS = 3'd6;

  // Gesture codes
  localparam logic [3:0] G_SPIN = 4'd0;
  localparam logic [3:0] G_CIRCLE = 4'd1;
  localparam logic [3:0] G_RIGHT = 4'd2;
  localparam logic [3:0] G_LEFT = 4'd3;
  localparam logic [3:0] G_DEFENDER = 4'd4;
  localparam logic [3:0] G_BACKWARD = 4'd5;
  localparam logic [3:0] G_HORIZONTAL = 4'd6;
  localparam logic [3:0] G_HOLD = 4'd7;
  localparam logic [3:0] G_SWIPE = 4'd8;
  localparam logic [3:0] G_DOUBLE = 4'd9;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DZ, ST_CIRC, ST_ANGLE, ST_ARC, ST_FL_START, ST_FL_DIR,
    ST_HOLD, ST_SWIPE, ST_BACK, ST_EMIT
  } state_t;

  // Arctangent table, 2^-32 turn units
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    begin
      unique case (i)
        5'd0: r = 32'h20000000; 5'd1: r = 32'h12E4051E; 5'd2: r = 32'h09FB385B;
        5'd3: r = 32'h051111D4; 5'd4: r = 32'h028B0D43; 5'd5: r = 32'h0145D7E1;
        5'd6: r = 32'h00A2F61E; 5'd7: r = 32'h00517C55; 5'd8: r = 32'h0028BE53;
        5'd9: r = 32'h00145F2F; 5'd10: r = 32'h000A2F98; 5'd11: r = 32'h000517CC;
        5'd12: r = 32'h00028BE6; 5'd13: r = 32'h000145F3; 5'd14: r = 32'h0000A2FA;
        5'd15: r = 32'h0000517D; 5'd16: r = 32'h000028BE; 5'd17: r = 32'h0000145F;
        5'd18: r = 32'h00000A30; 5'd19: r = 32'h00000518; 5'd20: r = 32'h0000028C;
        5'd21: r = 32'h00000146; 5'd22: r = 32'h000000A3; 5'd23: r = 32'h00000051;
        default: r = 32'h0;
      endcase
      return r;
    end
  endfunction

endpackage

### hdl/jgc_cordic.sv
// Vectoring CORDIC: one micro-rotation per cycle, angle in binary units.
module jgc_cordic import jgc_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic signed [11:0]    px,
  input  logic signed [11:0]    py,
  output logic                  done,
  output logic [ANGLE_BITS-1:0] angle
);
  localparam int NSTEP = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
  localparam int CW = $clog2(NSTEP + 1);
  // 12-bit inputs scaled by 2^16 grow by under 2x through the gain
  localparam int XW = 31;

  logic signed [XW-1:0] x, y;
  logic [31:0] acc;
  logic [CW-1:0] cnt;
  logic busy;

  logic signed [XW-1:0] xs, ys;
  logic [32:0] rnd;

  // Arithmetic shifts floor, matching the model's shift of negative values
  assign xs = x >>> cnt;
  assign ys = y >>> cnt;
  assign rnd = {1'b0, acc} + (33'd1 << (31 - ANGLE_BITS));
  assign angle = rnd[31 -: ANGLE_BITS];

  // Step the rotation; start folds the left half plane over
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= (px != 12'sd0) || (py != 12'sd0);
        done <= (px == 12'sd0) && (py == 12'sd0);
        cnt <= '0;
        if (px < 0) begin
          // Negate after widening so the most negative input flips cleanly
          x <= (-XW'(px)) <<< 16;
          y <= (-XW'(py)) <<< 16;
          acc <= 32'h80000000;
        end else begin
          x <= XW'(px) <<< 16;
          y <= XW'(py) <<< 16;
          acc <= 32'h0;
        end
      end else if (busy) begin
        if (y > 0) begin
          x <= x + ys;
          y <= y - xs;
          acc <= acc + atan_turn(5'(cnt));
        end else begin
          x <= x - ys;
          y <= y + xs;
          acc <= acc - atan_turn(5'(cnt));
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(NSTEP - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

### hdl/jgc_outq.sv
// Small gesture-code queue that drives the output stream.
module jgc_outq import jgc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  logic [3:0] code,
  input  logic       seal,
  output logic       empty,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast
);
  logic [3:0] q [5];
  logic [2:0] wr, rd;
  logic sealed;

  assign empty = (wr == rd);
  assign m_tvalid = sealed && !empty;
  assign m_tdata = {4'd0, q[rd]};
  assign m_tlast = (rd + 3'd1 == wr);

  // Collect codes, then release them once the sample is sealed
  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      sealed <= 1'b0;
    end else begin
      if (push) begin
        q[wr] <= code;
        wr <= wr + 3'd1;
      end
      // A sample with no gestures leaves the queue unsealed
      if (seal && (push || !empty)) sealed <= 1'b1;
      if (m_tvalid && m_tready) begin
        if (m_tlast) begin
          rd <= '0;
          wr <= '0;
          sealed <= 1'b0;
        end else begin
          rd <= rd + 3'd1;
        end
      end
    end
  end
endmodule

### hdl/joystick_gesture_classifier_unit.sv
// Top level of the joystick gesture classifier.
// One sample at a time: a sample is taken, checked against the dead zone,
// then passed through the circle, flick, hold, swipe and backward detectors
// under a sequencer that shares one squared-magnitude multiplier and a CORDIC
// that turns one micro-rotation per cycle. A dead-zone sample returns to idle
// after the dead-zone check; any other sample runs the remaining states, adding
// the CORDIC when an angle is needed, an arc update when a running circle is
// updated and a direction check when a flick is pending. The input then stays
// stalled until the gestures have drained, one transfer per cycle while the
// receiver is ready.
// Results are 0 to 5 gesture codes, tdata holds gesture, tlast marks the last.
module joystick_gesture_classifier_unit import jgc_pkg::*; #(
  parameter int ANGLE_BITS = 16,
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // pos_x[11:0], pos_y[23:12], step_x[36:24], step_y[49:37], time_ms[81:50]
  input  logic [87:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // gesture[3:0]
  output logic [7:0]  m_tdata,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  localparam int AW = ANGLE_BITS;
  localparam logic [AW:0] FULL = (AW+1)'(1) << AW;
  localparam logic [AW:0] CAP = {(AW+1){1'b1}};

  // Configuration registers
  logic [11:0] dead_zone, sideways_threshold;
  logic [15:0] circle_max_ms, flick_max_ms, sideways_hold_ms;
  logic [16:0] circle_min_arc;
  logic [12:0] flick_min_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      dead_zone <= 12'd205; circle_max_ms <= 16'd600; circle_min_arc <= 17'd49152;
      flick_min_step <= 13'd205; flick_max_ms <= 16'd150;
      sideways_threshold <= 12'd1434; sideways_hold_ms <= 16'd400;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEAD_ZONE: dead_zone <= cfg_data[11:0];
        REG_CIRCLE_MAX_MS: circle_max_ms <= cfg_data[15:0];
        REG_CIRCLE_MIN_ARC: circle_min_arc <= cfg_data;
        REG_FLICK_MIN_STEP: flick_min_step <= cfg_data[12:0];
        REG_FLICK_MAX_MS: flick_max_ms <= cfg_data[15:0];
        REG_SIDEWAYS_THRESHOLD: sideways_threshold <= cfg_data[11:0];
        REG_SIDEWAYS_HOLD_MS: sideways_hold_ms <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Sample registers
  logic signed [11:0] px, py;
  logic signed [12:0] sx, sy;
  logic [31:0] now;

  // Detector state
  logic circle_on, flick_on, hold_on, swipe_on, back_armed;
  logic [31:0] circle_start, flick_start, hold_start, swipe_start, back_time;
  logic [AW:0] arc_total;
  logic [AW-1:0] prev_angle;
  logic signed [11:0] flick_origin_x, flick_origin_y;
  logic [1:0] swipe_tally;

  state_t state, state_next;

  // Shared squarer: sum of two squares of 13-bit signed values
  logic signed [13:0] ma, mb;
  logic [27:0] msq;
  logic [27:0] m2;  // registered result
  assign msq = 28'($signed(ma) * $signed(ma)) + 28'($signed(mb) * $signed(mb));

  logic signed [12:0] dxc, dyc;
  assign dxc = 13'(px) - 13'(flick_origin_x);
  assign dyc = 13'(py) - 13'(flick_origin_y);

  // Square the operands that the following state compares
  always_comb begin
    ma = 14'(px);
    mb = 14'(py);
    priority case (state)
      ST_IDLE: begin
        ma = 14'($signed(s_tdata[11:0]));
        mb = 14'($signed(s_tdata[23:12]));
      end
      ST_CIRC, ST_ANGLE, ST_ARC: begin ma = 14'(sx); mb = 14'(sy); end
      ST_FL_START: begin ma = 14'(dxc); mb = 14'(dyc); end
      default: ;
    endcase
  end

  // CORDIC
  logic cstart, cdone;
  logic [AW-1:0] cang;
  jgc_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cstart), .px(px), .py(py),
    .done(cdone), .angle(cang)
  );

  // Output queue
  logic push, seal, qempty;
  logic [3:0] code;
  jgc_outq u_outq (
    .clk(clk), .rst(rst), .push(push), .code(code), .seal(seal), .empty(qempty),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  logic [31:0] el_c, el_f, el_h, el_s, el_b;
  assign el_c = now - circle_start;
  assign el_f = now - flick_start;
  assign el_h = now - hold_start;
  assign el_s = now - swipe_start;
  assign el_b = now - back_time;

  logic [AW-1:0] dang;
  logic [AW:0] darc, arc_sum, arc_new, minarc;
  assign dang = cang - prev_angle;
  assign darc = (dang > AW'(FULL >> 1)) ? (FULL - (AW+1)'(dang)) : (AW+1)'(dang);
  assign arc_sum = arc_total + darc;
  assign arc_new = (arc_sum < arc_total) ? CAP : arc_sum;
  assign minarc = (AW+1)'(({17'd0, circle_min_arc} << AW) >> 16);

  logic [11:0] axv, ayv;
  assign axv = px[11] ? 12'(-px) : 12'(px);
  assign ayv = py[11] ? 12'(-py) : 12'(py);

  // Squared-ratio compares on the registered magnitude
  logic [37:0] m2x25, m2x400, r9;
  logic [23:0] dz2;
  logic [25:0] fs2;
  assign m2x25 = 38'(m2) * 38'd25;
  assign m2x400 = 38'(m2) * 38'd400;
  assign r9 = 38'(m2) * 38'd9;
  assign dz2 = 24'(dead_zone) * 24'(dead_zone);
  assign fs2 = 26'(flick_min_step) * 26'(flick_min_step);

  logic [25:0] dx2, dy2;
  logic [37:0] dx25, dy25;
  assign dx2 = 26'($signed(dxc) * $signed(dxc));
  assign dy2 = 26'($signed(dyc) * $signed(dyc));
  assign dx25 = 38'(dx2) * 38'd25;
  assign dy25 = 38'(dy2) * 38'd25;

  logic new_item;
  assign s_tready = (state == ST_IDLE) && qempty;
  assign new_item = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cstart = 1'b0;
    seal = 1'b0;
    unique case (state)
      ST_IDLE: if (new_item) state_next = ST_DZ;
      ST_DZ: state_next = (m2 < 28'(dz2)) ? ST_IDLE : ST_CIRC;
      ST_CIRC: begin
        if (!circle_on) begin
          state_next = (m2x400 > 38'd169 * 38'(QONE * QONE)) ? ST_ANGLE : ST_FL_START;
          cstart = (m2x400 > 38'd169 * 38'(QONE * QONE));
        end else if (m2x25 < 38'd4 * 38'(QONE * QONE)) begin
          state_next = ST_FL_START;
        end else begin
          state_next = ST_ANGLE;
          cstart = 1'b1;
        end
      end
      ST_ANGLE: if (cdone) state_next = circle_on ? ST_ARC : ST_FL_START;
      ST_ARC: state_next = ST_FL_START;
      ST_FL_START: state_next = flick_on ? ST_FL_DIR : ST_HOLD;
      ST_FL_DIR: state_next = ST_HOLD;
      ST_HOLD: state_next = ST_SWIPE;
      ST_SWIPE: state_next = ST_BACK;
      ST_BACK: state_next = ST_EMIT;
      ST_EMIT: begin seal = 1'b1; state_next = ST_IDLE; end
      default: state_next = ST_IDLE;
    endcase
  end

  // Datapath of the detectors
  always_ff @(posedge clk) begin
    if (rst) begin
      circle_on <= 1'b0; flick_on <= 1'b0; hold_on <= 1'b0;
      swipe_on <= 1'b0; back_armed <= 1'b0;
      circle_start <= '0; flick_start <= '0; hold_start <= '0;
      swipe_start <= '0; back_time <= '0;
      arc_total <= '0; prev_angle <= '0;
      flick_origin_x <= '0; flick_origin_y <= '0; swipe_tally <= '0;
      push <= 1'b0; code <= G_SPIN; m2 <= '0;
    end else begin
      push <= 1'b0;
      m2 <= msq;
      if (new_item) begin
        px <= s_tdata[11:0]; py <= s_tdata[23:12];
        sx <= s_tdata[36:24]; sy <= s_tdata[49:37];
        now <= s_tdata[81:50];
      end
      unique case (state)
        ST_CIRC: begin
          if (!circle_on) begin
            if (m2x400 > 38'd169 * 38'(QONE * QONE)) begin
              circle_start <= now;
              arc_total <= '0;
            end
          end else if (m2x25 < 38'd4 * 38'(QONE * QONE)) begin
            circle_on <= 1'b0;
            arc_total <= '0;
          end
        end
        ST_ANGLE: if (cdone && !circle_on) begin
          circle_on <= 1'b1;
          prev_angle <= cang;
        end
        ST_ARC: begin
          prev_angle <= cang;
          arc_total <= arc_new;
          if (el_c <= 32'(circle_max_ms) && (arc_new >= FULL || arc_new >= minarc)) begin
            push <= 1'b1;
            code <= (arc_new >= FULL) ? G_SPIN : G_CIRCLE;
            circle_on <= 1'b0;
            arc_total <= '0;
          end else if (el_c > 32'(circle_max_ms)) begin
            circle_on <= 1'b0;
            arc_total <= '0;
          end
        end
        ST_FL_START: if (!flick_on && m2 >= 28'(fs2)) begin
          flick_on <= 1'b1;
          flick_origin_x <= px;
          flick_origin_y <= py;
          flick_start <= now;
        end
        ST_FL_DIR: if (el_f > 32'(flick_max_ms)) begin
          push <= 1'b1;
          flick_on <= 1'b0;
          if (dxc > 0 && dx25 > r9) code <= G_RIGHT;
          else if (dxc < 0 && dx25 > r9) code <= G_LEFT;
          else if (dyc < 0 && dy25 > r9) code <= G_DEFENDER;
          else if (dyc > 0 && dy25 > r9) code <= G_BACKWARD;
          else code <= G_HORIZONTAL;
        end
        ST_HOLD: begin
          // Sideways hold
          if (axv > sideways_threshold && 16'd10 * 16'(ayv) < 16'(3 * QONE)) begin
            if (!hold_on) begin
              hold_on <= 1'b1;
              hold_start <= now;
            end else if (el_h >= 32'(sideways_hold_ms)) begin
              push <= 1'b1;
              code <= G_HOLD;
              hold_on <= 1'b0;
            end
          end else begin
            hold_on <= 1'b0;
          end
        end
        ST_SWIPE: begin
          // Swipe up
          if (!swipe_on && 16'sd5 * 16'(sy) < -16'sd4096) begin
            swipe_on <= 1'b1;
            swipe_start <= now;
          end else if (swipe_on && el_s > SWIPE_MS) begin
            push <= 1'b1;
            swipe_on <= 1'b0;
            if (swipe_tally + 2'd1 >= 2'd2) begin
              code <= G_DOUBLE;
              swipe_tally <= '0;
            end else begin
              code <= G_SWIPE;
              swipe_tally <= swipe_tally + 2'd1;
            end
          end
        end
        ST_BACK: begin
          // Double backward flick
          if (16'sd5 * 16'(sy) > 16'sd4096) begin
            if (!back_armed) begin
              back_armed <= 1'b1;
              back_time <= now;
            end else if (el_b < BACK_GAP_MS) begin
              push <= 1'b1;
              code <= G_BACKWARD;
              back_armed <= 1'b0;
            end else begin
              back_time <= now;
            end
          end
        end
        default: ;
      endcase
    end
  end
endmodule
